>>> rtl/tmea_pkg.sv
// shared types and constants for the trimmed mean echo averager
package tmea_pkg;

  localparam int ECHO_W    = 15;
  localparam int AVG_W     = 16;
  localparam int CNT_W     = 9;
  localparam int SUM_W     = 23;
  localparam int SC_W      = 8;
  localparam int DIV_W     = 8;
  localparam int STEP_W    = 5;
  localparam int ADDR_W    = 2;
  localparam int DATA_W    = 32;

  localparam logic [AVG_W-1:0]  ECHO_MAX_US = 16'd25000;
  localparam logic [SUM_W-1:0]  SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [ECHO_W-1:0] MIN_RESET   = {ECHO_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [AVG_W-1:0]  AVG_MAX     = {AVG_W{1'b1}};
  localparam logic [SC_W-1:0]   SC_RESET    = 8'd1;
  localparam logic [CNT_W-1:0]  TRIM_EDGES  = 9'd2;
  localparam logic [STEP_W-1:0] DIV_LAST    = 5'(SUM_W - 1);

  localparam logic [ADDR_W-1:0] ADDR_SAMPLE_COUNT = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

>>> rtl/tmea_if.sv
// valid/ready channel interfaces for echo samples and averaged results
interface tmea_in_if import tmea_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ECHO_W-1:0] echo_us;

  modport source (output valid, output echo_us, input ready);
  modport sink   (input valid, input echo_us, output ready);
endinterface

interface tmea_out_if import tmea_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AVG_W-1:0]  average_us;
  logic [CNT_W-1:0]  valid_samples;
  logic              trimmed;

  modport source (output valid, output average_us, output valid_samples, output trimmed,
                  input ready);
  modport sink   (input valid, input average_us, input valid_samples, input trimmed,
                  output ready);
endinterface

>>> rtl/trimmed_mean_echo_averager.sv
// top level: batch min/max/sum accumulation and serial trimmed-mean divider
//
//  channel   dir   handshake        payload
//  in_ch     in    valid/ready      echo_us
//  out_ch    out   valid/ready      average_us, valid_samples, trimmed
//  apb       in    psel/penable     sample_count at byte address 0
//
// ready is high only in idle, so samples are taken back to back there; after the last
// attempt of a batch the block runs setup, 23 restoring divide steps and result load
// when the mean is trimmed, and setup and result load otherwise, with ready low
// the result sits in an output register, so samples of the next batch are
// taken while it waits; the load stalls only if the previous result is untaken
// synchronous active-high reset: sample_count 1, batch cleared, no result
module trimmed_mean_echo_averager import tmea_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  tmea_in_if.sink           in_ch,
  tmea_out_if.source        out_ch
);

  state_t             state, state_next;
  logic [SC_W-1:0]    sample_count;
  logic [SUM_W-1:0]   running_sum, running_sum_next;
  logic [ECHO_W-1:0]  running_min, running_min_next;
  logic [ECHO_W-1:0]  running_max, running_max_next;
  logic [CNT_W-1:0]   valid_count, valid_count_next;
  logic [CNT_W-1:0]   attempt_count, attempt_count_next;
  logic [SUM_W-1:0]   dividend, dividend_next;
  logic [DIV_W-1:0]   rem, rem_next;
  logic [DIV_W-1:0]   divisor, divisor_next;
  logic [STEP_W-1:0]  step, step_next;
  logic               out_valid;
  logic [AVG_W-1:0]   out_avg;
  logic [CNT_W-1:0]   out_cnt;
  logic               out_trim;
  logic               out_load;

  logic               in_xfer;
  logic               echo_ok;
  logic [SUM_W:0]     sum_wide;
  logic [CNT_W-1:0]   batch_len;
  logic [AVG_W:0]     edges;
  logic [DIV_W:0]     shifted;
  logic               ge;
  logic               trim;
  logic [SUM_W-1:0]   res_src;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SAMPLE_COUNT) ? {{(DATA_W-SC_W){1'b0}}, sample_count}
                                               : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SC_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_SAMPLE_COUNT) begin
      sample_count <= pwdata[SC_W-1:0];
    end
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign echo_ok     = (in_ch.echo_us != '0) && ({1'b0, in_ch.echo_us} <= ECHO_MAX_US);
  assign sum_wide    = {1'b0, running_sum} + {{(SUM_W+1-ECHO_W){1'b0}}, in_ch.echo_us};
  assign batch_len   = ((sample_count == '0) ? 9'd1 : {1'b0, sample_count}) + TRIM_EDGES;
  assign edges       = {2'b0, running_min} + {2'b0, running_max};
  assign shifted     = {rem, dividend[SUM_W-1]};
  assign ge          = shifted >= {1'b0, divisor};
  assign trim        = valid_count > TRIM_EDGES;
  assign res_src     = trim ? dividend : running_sum;
  assign out_load    = (state == ST_DONE) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    running_sum_next   = running_sum;
    running_min_next   = running_min;
    running_max_next   = running_max;
    valid_count_next   = valid_count;
    attempt_count_next = attempt_count;
    dividend_next      = dividend;
    rem_next           = rem;
    divisor_next       = divisor;
    step_next          = step;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (echo_ok) begin
            if (in_ch.echo_us < running_min) running_min_next = in_ch.echo_us;
            if (in_ch.echo_us > running_max) running_max_next = in_ch.echo_us;
            running_sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            if (valid_count != CNT_MAX) valid_count_next = valid_count + 9'd1;
          end
          if (attempt_count != CNT_MAX) attempt_count_next = attempt_count + 9'd1;
          if (attempt_count_next >= batch_len) begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        dividend_next = (running_sum > {{(SUM_W-AVG_W-1){1'b0}}, edges})
                      ? running_sum - {{(SUM_W-AVG_W-1){1'b0}}, edges} : '0;
        divisor_next  = DIV_W'(valid_count - TRIM_EDGES);
        rem_next      = '0;
        step_next     = '0;
        state_next    = trim ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        rem_next      = ge ? DIV_W'(shifted - {1'b0, divisor}) : shifted[DIV_W-1:0];
        dividend_next = {dividend[SUM_W-2:0], ge};
        step_next     = step + 5'd1;
        if (step == DIV_LAST) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          running_sum_next   = '0;
          running_min_next   = MIN_RESET;
          running_max_next   = '0;
          valid_count_next   = '0;
          attempt_count_next = '0;
          state_next         = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      running_min   <= MIN_RESET;
      running_max   <= '0;
      valid_count   <= '0;
      attempt_count <= '0;
    end else begin
      running_sum   <= running_sum_next;
      running_min   <= running_min_next;
      running_max   <= running_max_next;
      valid_count   <= valid_count_next;
      attempt_count <= attempt_count_next;
    end
  end

  always_ff @(posedge clk) begin
    dividend <= dividend_next;
    rem      <= rem_next;
    divisor  <= divisor_next;
    step     <= step_next;
  end

  // result register, held until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg  <= (res_src > {{(SUM_W-AVG_W){1'b0}}, AVG_MAX}) ? AVG_MAX
                                                             : res_src[AVG_W-1:0];
      out_cnt  <= valid_count;
      out_trim <= trim;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.average_us    = out_avg;
  assign out_ch.valid_samples = out_cnt;
  assign out_ch.trimmed       = out_trim;

endmodule

>>> rtl/tmea_checker.sv
// port-level checks on the result channel, bound to the top level
module tmea_checker import tmea_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [AVG_W-1:0] average_us,
  input logic [CNT_W-1:0] valid_samples,
  input logic             trimmed
);

  // a pending result stays up until transferred
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_trim: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (trimmed == (valid_samples > TRIM_EDGES)))
    else $error("trimmed flag disagrees with valid count");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_samples == '0 |-> average_us == '0)
    else $error("non-zero average with no valid samples");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind trimmed_mean_echo_averager tmea_checker u_tmea_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .average_us    (out_ch.average_us),
  .valid_samples (out_ch.valid_samples),
  .trimmed       (out_ch.trimmed)
);

>>> test/trimmed_mean_echo_averager_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the trimmed mean echo averager, with its own batch predictor
module trimmed_mean_echo_averager_test;
  import tmea_pkg::*;

  localparam int RANDOM_ITEMS  = 1200;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PCT      = 17;

  typedef struct packed {
    logic [AVG_W-1:0] average_us;
    logic [CNT_W-1:0] valid_samples;
    logic             trimmed;
  } echo_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tmea_in_if  in_ch ();
  tmea_out_if out_ch ();

  trimmed_mean_echo_averager u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [SC_W-1:0]   cfg_samples = SC_RESET;
  logic [SUM_W-1:0]  batch_sum;
  logic [ECHO_W-1:0] batch_min;
  logic [ECHO_W-1:0] batch_max;
  logic [CNT_W-1:0]  batch_valid;
  logic [CNT_W-1:0]  batch_attempts;
  echo_result_t      averages_due[$];

  logic [ECHO_W-1:0] echo_q[$];
  int                echoes_queued = 0;
  int                echoes_taken  = 0;
  int                send_idle_pct = IDLE_PCT;
  int                take_idle_pct = IDLE_PCT;
  int                hold_request  = 0;
  int                hold_left     = 0;
  int                fail_count    = 0;
  int                averages_seen = 0;
  int                trimmed_seen  = 0;
  int                empty_batches = 0;

  function automatic void clear_batch_sums();
    batch_sum      = '0;
    batch_min      = MIN_RESET;
    batch_max      = '0;
    batch_valid    = '0;
    batch_attempts = '0;
  endfunction

  function automatic void absorb_echo(logic [ECHO_W-1:0] echo);
    int unsigned  batch_len;
    int unsigned  edges;
    int unsigned  rest;
    int unsigned  avg;
    echo_result_t res;
    batch_len = ((cfg_samples == '0) ? 1 : cfg_samples) + TRIM_EDGES;
    // echoes beyond the limit are timeouts
    if (echo != '0 && echo <= ECHO_MAX_US) begin
      if (echo < batch_min) batch_min = echo;
      if (echo > batch_max) batch_max = echo;
      if (32'(batch_sum) + echo > 32'(SUM_MAX)) batch_sum = SUM_MAX;
      else batch_sum = batch_sum + echo;
      if (batch_valid != CNT_MAX) batch_valid++;
    end
    if (batch_attempts != CNT_MAX) batch_attempts++;
    if (batch_attempts < batch_len) return;
    res.trimmed = batch_valid > TRIM_EDGES;
    if (res.trimmed) begin
      edges = batch_min + batch_max;
      rest  = (batch_sum > edges) ? batch_sum - edges : 0;
      avg   = rest / (batch_valid - TRIM_EDGES);
    end else begin
      avg = batch_sum;
    end
    res.average_us    = (avg > AVG_MAX) ? AVG_MAX : avg[AVG_W-1:0];
    res.valid_samples = batch_valid;
    averages_due.push_back(res);
    clear_batch_sums();
  endfunction

  function automatic logic [ECHO_W-1:0] pick_echo();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 12) return '0;
    if (roll < 20) return ECHO_W'($urandom_range(MIN_RESET, ECHO_MAX_US + 16'd1));
    if (roll < 28) begin
      case ($urandom_range(3))
        0: return ECHO_W'(1);
        1: return ECHO_W'(ECHO_MAX_US);
        2: return ECHO_W'(ECHO_MAX_US + 16'd1);
        default: return MIN_RESET;
      endcase
    end
    return ECHO_W'($urandom_range(ECHO_MAX_US, 1));
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  task automatic queue_echo(logic [ECHO_W-1:0] echo);
    echo_q.push_back(echo);
    echoes_queued++;
  endtask

  task automatic write_sample_count(logic [SC_W-1:0] samples);
    logic [DATA_W-1:0] word;
    word            = $urandom();
    word[SC_W-1:0]  = samples;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_SAMPLE_COUNT;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_samples = samples;
  endtask

  // every queued sample taken and every average out, then let the divider settle
  task automatic wait_drain();
    do @(posedge clk); while (echoes_taken != echoes_queued || averages_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_echo(in_ch.echo_us);
        echoes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (echo_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.echo_us <= echo_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    echo_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (averages_due.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %0d/%0d/%0d", $time,
                   out_ch.average_us, out_ch.valid_samples, out_ch.trimmed);
          fail_count++;
        end else begin
          want = averages_due.pop_front();
          check_field("average_us", 32'(want.average_us), 32'(out_ch.average_us));
          check_field("valid_samples", 32'(want.valid_samples), 32'(out_ch.valid_samples));
          check_field("trimmed", 32'(want.trimmed), 32'(out_ch.trimmed));
          averages_seen++;
          if (want.trimmed) trimmed_seen++;
          if (want.valid_samples == '0) empty_batches++;
        end
      end
      if (hold_left == 0 && hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [ECHO_W-1:0] first_echoes[12] = '{
      0, 0, 0,
      25000, 1, 0,
      25001, 32767, 12345,
      1, 25000, 100
    };
    logic [SC_W-1:0] samples;
    int              n;
    int              roll;
    int              phase_no;
    int              random_queued;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.echo_us = '0;
    out_ch.ready  = 1'b0;
    clear_batch_sums();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset length of three attempts: silent batch, raw sums, timeouts, one trimmed batch
    foreach (first_echoes[i]) queue_echo(first_echoes[i]);
    wait_drain();
    write_sample_count('0);
    queue_echo(7);
    queue_echo(8);
    queue_echo(9);
    wait_drain();
    // shorten the batch once more attempts have passed than the new length
    write_sample_count(5);
    repeat (4) queue_echo(pick_echo());
    wait_drain();
    write_sample_count(1);
    queue_echo(pick_echo());
    wait_drain();

    phase_no      = 0;
    random_queued = 0;
    while (random_queued < RANDOM_ITEMS) begin
      send_idle_pct = IDLE_PCT;
      take_idle_pct = IDLE_PCT;
      roll          = $urandom_range(99);
      if (phase_no == 0) begin
        samples = '1;
        n       = 260;
      end else if (phase_no == 2) begin
        // long stretch with no idling on either side
        samples       = 2;
        n             = 200;
        send_idle_pct = 0;
        take_idle_pct = 0;
      end else if (phase_no == 4) begin
        // receiver held off while samples keep coming, so the block backs up
        samples       = 1;
        n             = 90;
        send_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
      end else if (roll < 10) begin
        samples = SC_W'($urandom_range(255, 254));
        n       = $urandom_range(300, 257);
      end else if (roll < 30) begin
        samples = SC_W'($urandom_range(255));
        n       = $urandom_range(120, 20);
      end else begin
        samples = SC_W'($urandom_range(8));
        n       = $urandom_range(120, 20);
      end
      write_sample_count(samples);
      repeat (n) queue_echo(pick_echo());
      random_queued += n;
      phase_no++;
      wait_drain();
    end

    $display("%0d echo samples over %0d sample_count settings, incl. 0, 1 and 255",
             echoes_taken, phase_no + 4);
    $display("%0d averages checked: %0d trimmed, %0d with no echo; one %0d-cycle output stall",
             averages_seen, trimmed_seen, empty_batches, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tmea_pkg.sv
rtl/tmea_if.sv
rtl/trimmed_mean_echo_averager.sv
rtl/tmea_checker.sv
test/trimmed_mean_echo_averager_test.sv
